FILE: rtl/core/lzfg_pkg.sv
// Package for the LZ flag-group decompressor core.
// Holds the controller/datapath command and status types and the fixed constants.
// No dependencies.
`default_nettype none
package lzfg_pkg;

  localparam int unsigned MIN_MATCH    = 3;
  localparam int unsigned GROUP_TOKENS = 8;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_OFF   = 2'd1;
  localparam logic [1:0] ST_OVERRUN   = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  typedef enum logic [1:0] {
    K_NONE,
    K_LIT,
    K_COPY
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_EMIT,
    S_STAT
  } state_t;

  typedef struct packed {
    logic take;
    logic rd;
    logic wr;
    logic emit;
    logic stat;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  take_eoi;
    logic  eoi;
    logic  pack_full;
    logic  copy_last;
    logic  copy_done;
    logic  out_free;
  } sts_t;

endpackage
`default_nettype wire

FILE: rtl/core/lzfg_ctrl.sv
// Controller state machine for the LZ flag-group decompressor.
// Depends on lzfg_pkg; drives command signals into lzfg_dp.
`default_nettype none
module lzfg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire lzfg_pkg::sts_t sts,
  output lzfg_pkg::cmd_t     cmd
);

  lzfg_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lzfg_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lzfg_pkg::S_IDLE: begin
        if (in_valid) begin
          case (sts.kind)
            lzfg_pkg::K_LIT:  state_nxt = lzfg_pkg::S_EMIT;
            lzfg_pkg::K_COPY: state_nxt = lzfg_pkg::S_RD;
            default:          state_nxt = sts.take_eoi ? lzfg_pkg::S_STAT : lzfg_pkg::S_IDLE;
          endcase
        end
      end
      lzfg_pkg::S_RD: state_nxt = lzfg_pkg::S_WR;
      lzfg_pkg::S_WR: begin
        if (sts.pack_full || sts.copy_last) begin
          state_nxt = lzfg_pkg::S_EMIT;
        end else begin
          state_nxt = lzfg_pkg::S_RD;
        end
      end
      lzfg_pkg::S_EMIT: begin
        if (sts.out_free) begin
          if (!sts.copy_done) begin
            state_nxt = lzfg_pkg::S_RD;
          end else if (sts.eoi) begin
            state_nxt = lzfg_pkg::S_STAT;
          end else begin
            state_nxt = lzfg_pkg::S_IDLE;
          end
        end
      end
      lzfg_pkg::S_STAT: begin
        if (sts.out_free) begin
          state_nxt = lzfg_pkg::S_IDLE;
        end
      end
      default: state_nxt = lzfg_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      lzfg_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      lzfg_pkg::S_RD:   cmd.rd   = 1'b1;
      lzfg_pkg::S_WR:   cmd.wr   = 1'b1;
      lzfg_pkg::S_EMIT: cmd.emit = sts.out_free;
      lzfg_pkg::S_STAT: cmd.stat = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: rtl/core/lzfg_dp.sv
// Datapath for the LZ flag-group decompressor: token decode, history memory,
// byte packer and output register. Depends on lzfg_pkg; commanded by lzfg_ctrl.
`default_nettype none
module lzfg_dp #(
  parameter int unsigned HISTORY_DEPTH    = 65536,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [23:0]    cfg_wdata,
  input  wire logic [7:0]     in_byte,
  input  wire logic           in_end_of_input,
  input  wire lzfg_pkg::cmd_t cmd,
  output lzfg_pkg::sts_t      sts,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [63:0]         out_bytes,
  output logic [3:0]          out_byte_count,
  output logic                out_run_last,
  output logic                out_frame_end,
  output logic [1:0]          out_frame_status
);

  localparam int unsigned AW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [16:0] DEPTH17 = 17'(HISTORY_DEPTH);
  localparam logic [AW-1:0] WPTR_MAX = AW'(HISTORY_DEPTH - 1);
  localparam logic [3:0] BPR_LAST = 4'(BYTES_PER_RESULT - 1);

  logic [7:0] hist_mem [HISTORY_DEPTH];

  logic [23:0]   out_size_r;
  logic [23:0]   pc_r;
  logic [AW-1:0] wptr_r;
  logic [7:0]    flags_r;
  logic [3:0]    gbit_r;
  logic [1:0]    phase_r;
  logic [15:0]   off_r;
  logic [1:0]    err_r;
  logic          eoi_r;
  logic [8:0]    rem_r;
  logic [7:0]    rd_data_r;
  logic [63:0]   pack_r;
  logic [3:0]    pcnt_r;
  logic          out_valid_r;
  logic [63:0]   out_bytes_r;
  logic [3:0]    out_count_r;
  logic          out_last_r;
  logic          out_fend_r;
  logic [1:0]    out_fstat_r;

  logic          done_w;
  logic          bad_off_w;
  logic          overrun_w;
  lzfg_pkg::kind_t kind_w;
  logic [16:0]   wp17_w;
  logic [16:0]   of17_w;
  logic [AW-1:0] src_w;
  logic          mem_we_w;
  logic [7:0]    mem_wd_w;
  logic          app_w;
  logic [7:0]    app_byte_w;
  logic          out_free_w;
  logic [1:0]    status_w;

  assign done_w    = (err_r != 2'd0) || (pc_r >= out_size_r);
  assign bad_off_w = (off_r == 16'd0) || ({8'd0, off_r} > pc_r) || ({1'b0, off_r} > DEPTH17);
  assign overrun_w = (25'(pc_r) + 25'(in_byte) + 25'(lzfg_pkg::MIN_MATCH)) > 25'(out_size_r);

  always_comb begin
    kind_w = lzfg_pkg::K_NONE;
    if (!done_w && gbit_r < 4'(lzfg_pkg::GROUP_TOKENS)) begin
      if (flags_r[gbit_r[2:0]]) begin
        kind_w = lzfg_pkg::K_LIT;
      end else if (phase_r == 2'd2 && !bad_off_w && !overrun_w) begin
        kind_w = lzfg_pkg::K_COPY;
      end
    end
  end

  // source address: write pointer minus offset, wrapped into the ring
  assign wp17_w = 17'(wptr_r);
  assign of17_w = {1'b0, off_r};
  assign src_w  = (wp17_w >= of17_w) ? AW'(wp17_w - of17_w)
                                     : AW'(wp17_w + DEPTH17 - of17_w);

  assign mem_we_w   = cmd.wr || (cmd.take && kind_w == lzfg_pkg::K_LIT);
  assign mem_wd_w   = cmd.wr ? rd_data_r : in_byte;
  assign app_w      = mem_we_w;
  assign app_byte_w = mem_wd_w;

  always_ff @(posedge clk) begin
    if (mem_we_w) begin
      hist_mem[wptr_r] <= mem_wd_w;
    end
    if (cmd.rd) begin
      rd_data_r <= hist_mem[src_w];
    end
  end

  assign out_free_w = !out_valid_r || out_ready;

  always_comb begin
    if (err_r != 2'd0) begin
      status_w = err_r;
    end else if (pc_r >= out_size_r) begin
      status_w = lzfg_pkg::ST_OK;
    end else begin
      status_w = lzfg_pkg::ST_TRUNCATED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_size_r  <= '0;
      pc_r        <= '0;
      wptr_r      <= '0;
      flags_r     <= '0;
      gbit_r      <= 4'(lzfg_pkg::GROUP_TOKENS);
      phase_r     <= '0;
      off_r       <= '0;
      err_r       <= '0;
      eoi_r       <= 1'b0;
      rem_r       <= '0;
      pack_r      <= '0;
      pcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        out_size_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready && !cmd.emit && !cmd.stat) begin
        out_valid_r <= 1'b0;
      end

      if (cmd.take) begin
        eoi_r <= in_end_of_input;
        rem_r <= '0;
        if (!done_w) begin
          if (gbit_r >= 4'(lzfg_pkg::GROUP_TOKENS)) begin
            flags_r <= in_byte;
            gbit_r  <= '0;
          end else if (flags_r[gbit_r[2:0]]) begin
            gbit_r <= gbit_r + 4'd1;
          end else if (phase_r == 2'd0) begin
            off_r   <= {8'd0, in_byte};
            phase_r <= 2'd1;
          end else if (phase_r == 2'd1) begin
            off_r   <= {in_byte, off_r[7:0]};
            phase_r <= 2'd2;
          end else begin
            phase_r <= 2'd0;
            gbit_r  <= gbit_r + 4'd1;
            if (bad_off_w) begin
              err_r <= lzfg_pkg::ST_BAD_OFF;
            end else if (overrun_w) begin
              err_r <= lzfg_pkg::ST_OVERRUN;
            end else begin
              rem_r <= 9'(in_byte) + 9'(lzfg_pkg::MIN_MATCH);
            end
          end
        end
      end

      if (cmd.wr) begin
        rem_r <= rem_r - 9'd1;
      end

      // append one byte to the packer and advance the history pointers
      if (app_w) begin
        for (int i = 0; i < 8; i++) begin
          if (pcnt_r == 4'(i)) begin
            pack_r[8*i +: 8] <= app_byte_w;
          end
        end
        pcnt_r <= pcnt_r + 4'd1;
        pc_r   <= pc_r + 24'd1;
        wptr_r <= (wptr_r == WPTR_MAX) ? '0 : wptr_r + AW'(1);
      end

      if (cmd.emit) begin
        out_valid_r <= 1'b1;
        out_bytes_r <= pack_r;
        out_count_r <= pcnt_r;
        out_last_r  <= (rem_r == 9'd0) && !eoi_r;
        out_fend_r  <= 1'b0;
        out_fstat_r <= lzfg_pkg::ST_OK;
        pack_r      <= '0;
        pcnt_r      <= '0;
      end

      if (cmd.stat) begin
        out_valid_r <= 1'b1;
        out_bytes_r <= '0;
        out_count_r <= '0;
        out_last_r  <= 1'b1;
        out_fend_r  <= 1'b1;
        out_fstat_r <= status_w;
        eoi_r       <= 1'b0;
        pc_r        <= '0;
        wptr_r      <= '0;
        flags_r     <= '0;
        gbit_r      <= 4'(lzfg_pkg::GROUP_TOKENS);
        phase_r     <= '0;
        off_r       <= '0;
        err_r       <= '0;
      end
    end
  end

  always_comb begin
    sts.kind      = kind_w;
    sts.take_eoi  = in_end_of_input;
    sts.eoi       = eoi_r;
    sts.pack_full = (pcnt_r == BPR_LAST);
    sts.copy_last = (rem_r == 9'd1);
    sts.copy_done = (rem_r == 9'd0);
    sts.out_free  = out_free_w;
  end

  assign out_valid        = out_valid_r;
  assign out_bytes        = out_bytes_r;
  assign out_byte_count   = out_count_r;
  assign out_run_last     = out_last_r;
  assign out_frame_end    = out_fend_r;
  assign out_frame_status = out_fstat_r;

endmodule
`default_nettype wire

FILE: rtl/core/lz_flag_group_decompressor_core.sv
// LZ flag-group decompressor core: top level joining controller and datapath.
// Depends on lzfg_pkg, lzfg_ctrl and lzfg_dp.
//
// Usage:
//   Input channel (in_valid/in_ready): one compressed word per handshake,
//   in_byte plus in_end_of_input marking the last word of a frame.
//   Result channel (out_valid/out_ready): packed output words of up to
//   BYTES_PER_RESULT bytes, first byte in bits 7:0, plus a status word
//   (out_frame_end high) after the end-of-input word.
//   Configuration: cfg_we/cfg_wdata set the expected frame size; write it
//   only while the core is idle.
// Steps:
//   Flag, offset and ignored words take only the accept step. A literal is
//   accepted, then loaded into the output register. A match is accepted, then
//   each byte is a history read then a history write, with an emit step per
//   result word. The status word adds a status step of its own.
// Reset: rst_n is synchronous; frame state, frame size and output valid
//   clear. History content is left as is and is never read before written.
// Stall: a result waits in the output register; the core accepts the next
//   word meanwhile, and holds in its emit or status step only when a second result is due.
`default_nettype none
module lz_flag_group_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH    = 65536,
  parameter int unsigned BYTES_PER_RESULT = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [23:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_input,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_bytes,
  output logic [3:0]       out_byte_count,
  output logic             out_run_last,
  output logic             out_frame_end,
  output logic [1:0]       out_frame_status
);

  lzfg_pkg::cmd_t cmd;
  lzfg_pkg::sts_t sts;

  // sequencing: accept, copy loop, emit and status steps
  lzfg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // decode state, history memory, packer and output register
  lzfg_dp #(
    .HISTORY_DEPTH    (HISTORY_DEPTH),
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_byte          (in_byte),
    .in_end_of_input  (in_end_of_input),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_bytes        (out_bytes),
    .out_byte_count   (out_byte_count),
    .out_run_last     (out_run_last),
    .out_frame_end    (out_frame_end),
    .out_frame_status (out_frame_status)
  );

endmodule
`default_nettype wire

FILE: tb/sv/tb_lz_flag_group_decompressor_core.sv
// Testbench for the LZ flag-group decompressor core: directed table then random frames,
// every output word checked against an in-bench decoder model.
// Depends on lzfg_pkg and lz_flag_group_decompressor_core.
`timescale 1ns / 1ps
module tb_lz_flag_group_decompressor_core;

  localparam int unsigned HIST = 65536;
  localparam int unsigned WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  count;
    logic        run_last;
    logic        frame_end;
    logic [1:0]  status;
  } out_word_t;

  // directed row: stimulus word plus an optional typed-in status check
  typedef struct {
    logic [7:0] b;
    logic       eoi;
    bit         fixed;
    logic [1:0] fixed_status;
  } row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [23:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_end_of_input;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_bytes;
  logic [3:0]  out_byte_count;
  logic        out_run_last;
  logic        out_frame_end;
  logic [1:0]  out_frame_status;

  lz_flag_group_decompressor_core DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .in_end_of_input(in_end_of_input), .out_valid(out_valid), .out_ready(out_ready),
    .out_bytes(out_bytes), .out_byte_count(out_byte_count), .out_run_last(out_run_last),
    .out_frame_end(out_frame_end), .out_frame_status(out_frame_status)
  );

  // Decoder model state
  logic [7:0]  hist_mem [HIST];
  logic [23:0] produced;
  logic [7:0]  flags;
  logic [3:0]  flag_pos;
  logic [1:0]  phase;
  logic [15:0] off_hold;
  logic [1:0]  err;
  logic [23:0] frame_size;
  out_word_t   pending_words[$];
  int          errors;
  bit          stalls_on;

  initial clk = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Decode one compressed word and queue the output words it should cause.
  task automatic decode_word(input logic [7:0] b, input logic eoi);
    logic [7:0]  run[$];
    logic [23:0] len;
    logic [15:0] src;
    out_word_t   w;
    int          pos;
    run = {};
    if (err == lzfg_pkg::ST_OK && produced < frame_size) begin
      if (flag_pos >= lzfg_pkg::GROUP_TOKENS) begin
        flags = b;
        flag_pos = '0;
      end else if (flags[flag_pos[2:0]]) begin
        hist_mem[produced[15:0]] = b;
        run = {run, b};
        produced++;
        flag_pos++;
      end else if (phase == 2'd0) begin
        off_hold[7:0] = b;
        phase = 2'd1;
      end else if (phase == 2'd1) begin
        off_hold[15:8] = b;
        phase = 2'd2;
      end else begin
        phase = 2'd0;
        flag_pos++;
        len = 24'(b) + 24'(lzfg_pkg::MIN_MATCH);
        if (off_hold == 16'd0 || 24'(off_hold) > produced) err = lzfg_pkg::ST_BAD_OFF;
        else if (25'(produced) + 25'(len) > 25'(frame_size)) err = lzfg_pkg::ST_OVERRUN;
        else begin
          for (int k = 0; k < int'(len); k++) begin
            // overlap: source may be a byte written by this same match
            src = produced[15:0] - off_hold;
            hist_mem[produced[15:0]] = hist_mem[src];
            run = {run, hist_mem[src]};
            produced++;
          end
        end
      end
    end
    pos = 0;
    while (pos < run.size()) begin
      w = '0;
      while (w.count < 4'd8 && pos < run.size()) begin
        w.bytes[8*w.count +: 8] = run[pos];
        w.count++;
        pos++;
      end
      w.run_last = !eoi && pos >= run.size();
      pending_words = {pending_words, w};
    end
    if (eoi) begin
      w = '0;
      w.run_last = 1'b1;
      w.frame_end = 1'b1;
      if (err != lzfg_pkg::ST_OK) w.status = err;
      else if (produced >= frame_size) w.status = lzfg_pkg::ST_OK;
      else w.status = lzfg_pkg::ST_TRUNCATED;
      pending_words = {pending_words, w};
      produced = '0; flags = '0; flag_pos = 4'(lzfg_pkg::GROUP_TOKENS); phase = '0;
      off_hold = '0;
      err = lzfg_pkg::ST_OK;
    end
  endtask

  // Result side: random stall, compare each accepted word with the oldest one due.
  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) out_ready <= 1'b0;
    else begin
      if (out_valid && out_ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected output word %h", out_bytes);
          errors++;
        end else begin
          e = pending_words.pop_front();
          if (out_bytes !== e.bytes) begin
            $error("out_bytes exp %h got %h", e.bytes, out_bytes); errors++;
          end
          if (out_byte_count !== e.count) begin
            $error("byte_count exp %0d got %0d", e.count, out_byte_count); errors++;
          end
          if (out_run_last !== e.run_last) begin
            $error("run_last exp %0d got %0d", e.run_last, out_run_last); errors++;
          end
          if (out_frame_end !== e.frame_end) begin
            $error("frame_end exp %0d got %0d", e.frame_end, out_frame_end); errors++;
          end
          if (out_frame_status !== e.status) begin
            $error("frame_status exp %0d got %0d", e.status, out_frame_status); errors++;
          end
        end
      end
      out_ready <= stalls_on ? ($urandom_range(99) >= 24) : 1'b1;
    end
  end

  // Watchdog: count cycles with no handshake on either channel.
  int idle_cycles;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Hold the word until accepted, then decode it into the model; valid stays
  // high afterwards so the next word can follow without a gap.
  task automatic send_word(input logic [7:0] b, input logic eoi);
    while (stalls_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    in_end_of_input <= eoi;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_word(b, eoi);
  endtask

  // Drop valid, wait for every word due plus settling time, then write the frame size.
  task automatic set_frame_size(input logic [23:0] sz);
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= sz;
    @(posedge clk);
    cfg_we <= 1'b0;
    frame_size = sz;
  endtask

  // Random frame: random flag groups, mostly short-offset matches with occasional random offsets and lengths.
  task automatic random_frame(input int tokens, input bit clean_end);
    logic [7:0] f;
    int made;
    int off;
    made = 0;
    for (int t = 0; t < tokens; t += 8) begin
      f = 8'($urandom_range(255));
      if (made == 0) f[0] = 1'b1;
      send_word(f, 1'b0);
      for (int i = 0; i < 8 && t + i < tokens; i++) begin
        if (f[i] || made == 0) begin
          send_word(8'($urandom_range(255)), 1'b0);
          made++;
        end else begin
          off = ($urandom_range(9) == 0) ? int'($urandom_range(65535))
                                         : int'($urandom_range(made, 1));
          send_word(off[7:0], 1'b0);
          send_word(off[15:8], 1'b0);
          send_word(8'(($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(12)),
                    1'b0);
          if (off <= made) made += 3;
        end
      end
    end
    send_word(8'($urandom_range(255)), clean_end ? 1'b1 : 1'($urandom_range(1)));
    if (pending_words.size() == 0 || !pending_words[$].frame_end) send_word(8'h00, 1'b1);
  endtask

  row_t rows_empty [2];
  row_t rows_main [20];

  initial begin
    errors = 0;
    stalls_on = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_byte = '0;
    in_end_of_input = 1'b0;
    produced = '0; flags = '0; flag_pos = 4'(lzfg_pkg::GROUP_TOKENS); phase = '0;
    off_hold = '0;
    err = lzfg_pkg::ST_OK; frame_size = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // size zero after reset: frame already complete, bytes dropped
    rows_empty = '{'{8'hFF, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b1, 1'b1, lzfg_pkg::ST_OK}};
    foreach (rows_empty[i]) begin
      send_word(rows_empty[i].b, rows_empty[i].eoi);
      if (rows_empty[i].fixed && pending_words[$].status !== rows_empty[i].fixed_status) begin
        $error("table status exp %0d", rows_empty[i].fixed_status); errors++;
      end
    end

    set_frame_size(24'd20);
    // literals, bad offsets, overrun, truncation
    rows_main = '{
      '{8'hFD, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 2'd0}, '{8'h80, 1'b0, 1'b0, 2'd0}, '{8'h01, 1'b0, 1'b0, 2'd0},
      '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h05, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b1, 1'b0, 2'd0},
      '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'h00, 1'b0, 1'b0, 2'd0},
      '{8'h00, 1'b1, 1'b1, lzfg_pkg::ST_BAD_OFF},
      '{8'h01, 1'b0, 1'b0, 2'd0}, '{8'h41, 1'b0, 1'b0, 2'd0}, '{8'h01, 1'b0, 1'b0, 2'd0},
      '{8'h00, 1'b0, 1'b0, 2'd0}, '{8'hFF, 1'b1, 1'b1, lzfg_pkg::ST_OVERRUN},
      '{8'hFF, 1'b0, 1'b0, 2'd0}, '{8'h7E, 1'b1, 1'b1, lzfg_pkg::ST_TRUNCATED}
    };
    foreach (rows_main[i]) begin
      send_word(rows_main[i].b, rows_main[i].eoi);
      if (rows_main[i].fixed && pending_words[$].status !== rows_main[i].fixed_status) begin
        $error("table status exp %0d", rows_main[i].fixed_status); errors++;
      end
    end

    // a frame against the maximum size register: never complete
    set_frame_size(24'hFFFFFF);
    random_frame(12, 1'b1);

    for (int f = 0; f < 8; f++) begin
      stalls_on = (f > 2);
      set_frame_size((f % 5 == 0) ? 24'($urandom_range(300, 40)) : 24'($urandom_range(60, 1)));
      random_frame(int'($urandom_range(20, 4)), 1'b0);
    end

    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
